// File: sv/ssa_pkg.sv
// shared constants and types for the swap slot allocator
`timescale 1ns / 1ps

package ssa_pkg;

    localparam int SLOTS            = 1024;
    localparam int SECTORS_PER_PAGE = 8;
    localparam int SECTOR_BYTES     = 512;

    // port field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 10;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SECTOR_W = 13;
    localparam int AVAIL_W  = 11;

    // bitmap layout: one ram word holds WORD_W slot flags
    localparam int WORD_W  = 32;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int WORDS   = SLOTS / WORD_W;
    localparam int WORD_AW = $clog2(WORDS);

    localparam int CNT_W = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;

    localparam logic [OP_W-1:0] OP_STORE   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [OP_W-1:0] OP_DISCARD = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // work handed from the bitmap control to the sector sequencer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   page;
        logic                is_read;
        logic                whole_page;
    } t_job;

endpackage

// File: sv/swap_slot_allocator_unit.sv
// swap slot allocator top level: config register, bitmap control, sector sequencer
//
//  channel   direction  handshake                  payload
//  cfg       in         i_cfg_valid / o_cfg_ready  i_slots_available
//  in        in         i_in_valid / o_in_ready    i_operation, i_slot_index, i_page_address
//  out       out        o_out_valid / i_out_ready  o_status .. o_last
//
// one item at a time in the bitmap control; each bitmap word takes a ram read state,
// then a check and write back state, so a store that finds its slot in word w scans
// words 0 to w before the job is handed over, load and discard read only one word.
// the sequencer sends 8 beats for store or load, 1 for discard or an error, one per
// cycle while out is ready, and the next item is taken meanwhile.
// reset: bitmap rows carry valid flags cleared at once, no clearing pass.
// a stalled out channel holds the current beat and backs up into the in channel.
`timescale 1ns / 1ps

module swap_slot_allocator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ssa_pkg::AVAIL_W-1:0]     i_slots_available,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ssa_pkg::OP_W-1:0]        i_operation,
    input  logic [ssa_pkg::SLOT_W-1:0]      i_slot_index,
    input  logic [ssa_pkg::ADDR_W-1:0]      i_page_address,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ssa_pkg::STATUS_W-1:0]    o_status,
    output logic [ssa_pkg::SLOT_W-1:0]      o_slot_number,
    output logic [ssa_pkg::SECTOR_W-1:0]    o_sector_address,
    output logic [ssa_pkg::ADDR_W-1:0]      o_buffer_address,
    output logic                            o_is_read,
    output logic                            o_last
);

    logic [ssa_pkg::AVAIL_W-1:0] r_slots_avail;
    logic [ssa_pkg::AVAIL_W-1:0] avail;
    logic                        job_valid;
    logic                        job_ready;
    ssa_pkg::t_job               job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_avail <= ssa_pkg::AVAIL_W'(1024);
        end else if (i_cfg_valid) begin
            r_slots_avail <= i_slots_available;
        end
    end

    assign o_cfg_ready = 1'b1;

    // usable count is capped at the bitmap size
    assign avail = (r_slots_avail > ssa_pkg::AVAIL_W'(ssa_pkg::SLOTS)) ?
                   ssa_pkg::AVAIL_W'(ssa_pkg::SLOTS) : r_slots_avail;

    ssa_alloc u_alloc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_slot_index   (i_slot_index),
        .i_page_address (i_page_address),
        .i_avail        (avail),
        .o_job_valid    (job_valid),
        .i_job_ready    (job_ready),
        .o_job          (job)
    );

    ssa_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (job_valid),
        .o_job_ready      (job_ready),
        .i_job            (job),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_slot_number    (o_slot_number),
        .o_sector_address (o_sector_address),
        .o_buffer_address (o_buffer_address),
        .o_is_read        (o_is_read),
        .o_last           (o_last)
    );

endmodule

// File: sv/ssa_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module ssa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ssa_alloc.sv
// bitmap control: slot scan, claim and free over the bitmap ram
`timescale 1ns / 1ps

module ssa_alloc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ssa_pkg::OP_W-1:0]       i_operation,
    input  logic [ssa_pkg::SLOT_W-1:0]     i_slot_index,
    input  logic [ssa_pkg::ADDR_W-1:0]     i_page_address,
    input  logic [ssa_pkg::AVAIL_W-1:0]    i_avail,
    output logic                           o_job_valid,
    input  logic                           i_job_ready,
    output ssa_pkg::t_job                  o_job
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CHK  = 4'b0100,
        S_HAND = 4'b1000
    } t_state;

    t_state                             r_state, n_state;
    logic [ssa_pkg::OP_W-1:0]           r_op, n_op;
    logic [ssa_pkg::SLOT_W-1:0]         r_idx, n_idx;
    logic [ssa_pkg::ADDR_W-1:0]         r_page, n_page;
    logic [ssa_pkg::WORD_AW-1:0]        r_word, n_word;
    ssa_pkg::t_job                      r_job, n_job;
    logic [ssa_pkg::WORDS-1:0]          r_row_valid, n_row_valid;

    logic                               ram_we;
    logic [ssa_pkg::WORD_W-1:0]         ram_wdata;
    logic [ssa_pkg::WORD_W-1:0]         ram_q;
    logic [ssa_pkg::WORD_W-1:0]         word_q;
    logic [ssa_pkg::WORD_AW:0]          lim_word;
    logic [ssa_pkg::WORD_AW:0]          word_ext;
    logic [ssa_pkg::BIT_W-1:0]          tail;
    logic [ssa_pkg::WORD_W-1:0]         in_range;
    logic [ssa_pkg::WORD_W-1:0]         busy_bits;
    logic [ssa_pkg::BIT_W-1:0]          free_bit;
    logic                               free_any;
    logic                               last_word;

    ssa_ram #(
        .WIDTH (ssa_pkg::WORD_W),
        .DEPTH (ssa_pkg::WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_raddr (r_word),
        .o_rdata (ram_q)
    );

    // a row never written since reset reads as all free
    assign word_q = r_row_valid[r_word] ? ram_q : '0;

    // flags at or above the available count are treated as taken
    assign lim_word = i_avail[ssa_pkg::AVAIL_W-1:ssa_pkg::BIT_W];
    assign word_ext = {1'b0, r_word};
    assign tail     = i_avail[ssa_pkg::BIT_W-1:0];

    always_comb begin
        if (word_ext < lim_word) begin
            in_range = '1;
        end else if (word_ext == lim_word) begin
            in_range = (ssa_pkg::WORD_W'(1) << tail) - ssa_pkg::WORD_W'(1);
        end else begin
            in_range = '0;
        end
    end

    assign busy_bits = word_q | ~in_range;
    assign free_any  = ~&busy_bits;
    assign last_word = (word_ext >= lim_word) ||
                       (r_word == ssa_pkg::WORD_AW'(ssa_pkg::WORDS - 1));

    // lowest free flag in the word
    always_comb begin
        free_bit = '0;
        for (int b = ssa_pkg::WORD_W - 1; b >= 0; b--) begin
            if (!busy_bits[b]) begin
                free_bit = ssa_pkg::BIT_W'(b);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_page      = r_page;
        n_word      = r_word;
        n_job       = r_job;
        n_row_valid = r_row_valid;
        ram_we      = 1'b0;
        ram_wdata   = word_q;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op   = i_operation;
                    n_idx  = i_slot_index;
                    n_page = i_page_address;
                    n_job  = '0;
                    unique case (i_operation) inside
                        ssa_pkg::OP_STORE: begin
                            if (i_avail == '0) begin
                                n_job.status = ssa_pkg::ST_FULL;
                                n_state      = S_HAND;
                            end else begin
                                n_word  = '0;
                                n_state = S_RD;
                            end
                        end
                        ssa_pkg::OP_LOAD, ssa_pkg::OP_DISCARD: begin
                            if ({1'b0, i_slot_index} >= i_avail) begin
                                n_job.status = ssa_pkg::ST_RANGE;
                                n_job.slot   = i_slot_index;
                                n_state      = S_HAND;
                            end else begin
                                n_word  = i_slot_index[ssa_pkg::SLOT_W-1:ssa_pkg::BIT_W];
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_op == ssa_pkg::OP_STORE) begin
                    if (free_any) begin
                        ram_we              = 1'b1;
                        ram_wdata           = word_q | (ssa_pkg::WORD_W'(1) << free_bit);
                        n_row_valid[r_word] = 1'b1;
                        n_job.status        = ssa_pkg::ST_OK;
                        n_job.slot          = {r_word, free_bit};
                        n_job.page          = r_page;
                        n_job.is_read       = 1'b0;
                        n_job.whole_page    = 1'b1;
                        n_state             = S_HAND;
                    end else if (last_word) begin
                        n_job.status = ssa_pkg::ST_FULL;
                        n_state      = S_HAND;
                    end else begin
                        n_word  = r_word + ssa_pkg::WORD_AW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    // load or discard frees the slot, a free slot stays free
                    ram_we              = 1'b1;
                    ram_wdata           = word_q &
                        ~(ssa_pkg::WORD_W'(1) << r_idx[ssa_pkg::BIT_W-1:0]);
                    n_row_valid[r_word] = 1'b1;
                    n_job.status        = ssa_pkg::ST_OK;
                    n_job.slot          = r_idx;
                    if (r_op == ssa_pkg::OP_LOAD) begin
                        n_job.page       = r_page;
                        n_job.is_read    = 1'b1;
                        n_job.whole_page = 1'b1;
                    end
                    n_state = S_HAND;
                end
            end
            S_HAND: begin
                if (i_job_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
        end
        r_op   <= n_op;
        r_idx  <= n_idx;
        r_page <= n_page;
        r_word <= n_word;
        r_job  <= n_job;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_HAND);
    assign o_job       = r_job;

endmodule

// File: sv/ssa_emit.sv
// sector sequencer: turns one job into result beats behind an output register
`timescale 1ns / 1ps

module ssa_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    output logic                            o_job_ready,
    input  ssa_pkg::t_job                   i_job,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ssa_pkg::STATUS_W-1:0]    o_status,
    output logic [ssa_pkg::SLOT_W-1:0]      o_slot_number,
    output logic [ssa_pkg::SECTOR_W-1:0]    o_sector_address,
    output logic [ssa_pkg::ADDR_W-1:0]      o_buffer_address,
    output logic                            o_is_read,
    output logic                            o_last
);

    ssa_pkg::t_job                     r_job;
    logic                              r_busy;
    logic [ssa_pkg::CNT_W-1:0]         r_cnt;
    logic                              r_out_valid;
    logic [ssa_pkg::STATUS_W-1:0]      r_status;
    logic [ssa_pkg::SLOT_W-1:0]        r_slot;
    logic [ssa_pkg::SECTOR_W-1:0]      r_sector;
    logic [ssa_pkg::ADDR_W-1:0]        r_buffer;
    logic                              r_is_read;
    logic                              r_last;

    logic                              advance;
    logic                              beat_last;
    logic [ssa_pkg::SECTOR_W-1:0]      sector;
    logic [ssa_pkg::ADDR_W-1:0]        buffer;

    assign advance     = !r_out_valid || i_out_ready;
    assign o_job_ready = !r_busy;

    assign beat_last = !r_job.whole_page ||
                       (r_cnt == ssa_pkg::CNT_W'(ssa_pkg::SECTORS_PER_PAGE - 1));

    assign sector = ssa_pkg::SECTOR_W'(r_job.slot) *
                    ssa_pkg::SECTOR_W'(ssa_pkg::SECTORS_PER_PAGE) +
                    ssa_pkg::SECTOR_W'(r_cnt);
    assign buffer = r_job.page +
                    ssa_pkg::ADDR_W'(ssa_pkg::SECTOR_BYTES) * ssa_pkg::ADDR_W'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_busy && i_job_valid) begin
                r_busy <= 1'b1;
            end else if (r_busy && advance && beat_last) begin
                r_busy <= 1'b0;
            end
            if (r_busy && advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (!r_busy && i_job_valid) begin
            r_job <= i_job;
            r_cnt <= '0;
        end else if (r_busy && advance) begin
            r_cnt <= r_cnt + ssa_pkg::CNT_W'(1);
        end

        if (r_busy && advance) begin
            r_status  <= r_job.status;
            r_slot    <= r_job.slot;
            r_sector  <= r_job.whole_page ? sector : '0;
            r_buffer  <= r_job.whole_page ? buffer : '0;
            r_is_read <= r_job.is_read;
            r_last    <= beat_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_slot_number    = r_slot;
    assign o_sector_address = r_sector;
    assign o_buffer_address = r_buffer;
    assign o_is_read        = r_is_read;
    assign o_last           = r_last;

endmodule

// File: test/slot_beat_checker.sv
// checker for the swap slot allocator: predicts sector beats and compares the out channel
`timescale 1ns / 1ps

module slot_beat_checker import ssa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [AVAIL_W-1:0]  i_slots_available,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [SLOT_W-1:0]   i_slot_index,
    input  logic [ADDR_W-1:0]   i_page_address,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [SLOT_W-1:0]   i_slot_number,
    input  logic [SECTOR_W-1:0] i_sector_address,
    input  logic [ADDR_W-1:0]   i_buffer_address,
    input  logic                i_is_read,
    input  logic                i_last,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] sector;
        logic [ADDR_W-1:0]   buffer;
        logic                is_read;
        logic                last;
    } sector_beat_t;

    sector_beat_t       beats_due[$];
    logic [SLOTS-1:0]   slot_used;
    int                 used_slots;
    logic [AVAIL_W-1:0] slots_cfg;

    task automatic queue_beat(input logic [STATUS_W-1:0] status, input logic [SLOT_W-1:0] slot,
                              input logic [SECTOR_W-1:0] sector, input logic [ADDR_W-1:0] buffer,
                              input logic is_read, input logic last);
        sector_beat_t beat;
        beat.status  = status;
        beat.slot    = slot;
        beat.sector  = sector;
        beat.buffer  = buffer;
        beat.is_read = is_read;
        beat.last    = last;
        beats_due.push_back(beat);
    endtask

    task automatic queue_page(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] page,
                              input logic is_read);
        int k;
        for (k = 0; k < SECTORS_PER_PAGE; k++) begin
            queue_beat(ST_OK, slot, SECTOR_W'(int'(slot) * SECTORS_PER_PAGE + k),
                       page + ADDR_W'(SECTOR_BYTES * k), is_read, k == SECTORS_PER_PAGE - 1);
        end
    endtask

    task automatic predict_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx,
                                input logic [ADDR_W-1:0] page);
        int limit;
        int s;
        limit = (int'(slots_cfg) > SLOTS) ? SLOTS : int'(slots_cfg);
        case (op)
            OP_STORE: begin
                s = 0;
                while (s < limit && slot_used[s]) s++;
                if (s >= limit) begin
                    queue_beat(ST_FULL, '0, '0, '0, 1'b0, 1'b1);
                end else begin
                    slot_used[s] = 1'b1;
                    used_slots++;
                    queue_page(SLOT_W'(s), page, 1'b0);
                end
            end
            OP_LOAD, OP_DISCARD: begin
                if (int'(idx) >= limit) begin
                    queue_beat(ST_RANGE, idx, '0, '0, 1'b0, 1'b1);
                end else begin
                    if (op == OP_LOAD) begin
                        queue_page(idx, page, 1'b1);
                    end else begin
                        queue_beat(ST_OK, idx, '0, '0, 1'b0, 1'b1);
                    end
                    // freeing a slot that is already free changes nothing
                    if (slot_used[idx]) begin
                        slot_used[idx] = 1'b0;
                        if (used_slots > 0) used_slots--;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_beat();
        sector_beat_t want;
        if (beats_due.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("unexpected beat: status %0d slot %0d sector %0d buffer %h read %0d last %0d",
                         i_status, i_slot_number, i_sector_address, i_buffer_address,
                         i_is_read, i_last);
            end
        end else begin
            want = beats_due.pop_front();
            if (want.status !== i_status || want.slot !== i_slot_number ||
                want.sector !== i_sector_address || want.buffer !== i_buffer_address ||
                want.is_read !== i_is_read || want.last !== i_last) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display("beat mismatch: expected status %0d slot %0d sector %0d buffer %h read %0d last %0d",
                             want.status, want.slot, want.sector, want.buffer, want.is_read,
                             want.last);
                    $display("               actual   status %0d slot %0d sector %0d buffer %h read %0d last %0d",
                             i_status, i_slot_number, i_sector_address, i_buffer_address,
                             i_is_read, i_last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            beats_due.delete();
            slot_used    = '0;
            used_slots   = 0;
            slots_cfg    = AVAIL_W'(1024);
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) slots_cfg = i_slots_available;
            if (i_in_valid && i_in_ready) predict_item(i_operation, i_slot_index, i_page_address);
            if (i_out_valid && i_out_ready) check_beat();
        end
        o_pending = beats_due.size();
    end

endmodule

// File: test/swap_slot_allocator_unit_tb.sv
// testbench top for the swap slot allocator: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module swap_slot_allocator_unit_tb;
    import ssa_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [AVAIL_W-1:0]  i_slots_available;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_operation;
    logic [SLOT_W-1:0]   i_slot_index;
    logic [ADDR_W-1:0]   i_page_address;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot_number;
    logic [SECTOR_W-1:0] o_sector_address;
    logic [ADDR_W-1:0]   o_buffer_address;
    logic                o_is_read;
    logic                o_last;

    int                 fail_count;
    int                 pending;
    bit                 calm;
    logic [AVAIL_W-1:0] slots_setting;
    logic [AVAIL_W-1:0] phase_slots [PHASES];
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  idx;
    int                 roll;
    int                 limit;
    int                 n;
    int                 p;

    always #1 i_clk = ~i_clk;

    swap_slot_allocator_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_slots_available (i_slots_available),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_slot_index      (i_slot_index),
        .i_page_address    (i_page_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_slot_number     (o_slot_number),
        .o_sector_address  (o_sector_address),
        .o_buffer_address  (o_buffer_address),
        .o_is_read         (o_is_read),
        .o_last            (o_last)
    );

    slot_beat_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_slots_available (i_slots_available),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_slot_index      (i_slot_index),
        .i_page_address    (i_page_address),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_status          (o_status),
        .i_slot_number     (o_slot_number),
        .i_sector_address  (o_sector_address),
        .i_buffer_address  (o_buffer_address),
        .i_is_read         (o_is_read),
        .i_last            (o_last),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // out side back-pressure in random bursts
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // called at a falling edge; leaves valid high for a following beat
    task automatic send_item(input logic [OP_W-1:0] item_op, input logic [SLOT_W-1:0] item_idx,
                             input logic [ADDR_W-1:0] item_page);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_operation    = item_op;
        i_slot_index   = item_idx;
        i_page_address = item_page;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_slots(input logic [AVAIL_W-1:0] value);
        wait_drained();
        // an ignored opcode leaves no beat behind, so give the block time to settle
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_slots_available = value;
        i_cfg_valid       = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid   = 1'b0;
        slots_setting = value;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_slots_available = '0;
        i_in_valid        = 1'b0;
        i_operation       = OP_STORE;
        i_slot_index      = '0;
        i_page_address    = '0;
        calm              = 1'b0;
        slots_setting     = AVAIL_W'(1024);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset setting of 1024 slots
        send_item(OP_STORE,   '0,            32'h0000_0000);
        send_item(OP_STORE,   '0,            32'hFFFF_FFFF);  // buffer wraps
        send_item(OP_LOAD,    SLOT_W'(0),    32'hFFFF_F000);
        send_item(OP_LOAD,    SLOT_W'(1023), 32'h1234_5678);  // top slot, never stored
        send_item(OP_DISCARD, SLOT_W'(1),    32'h0000_0000);
        send_item(OP_DISCARD, SLOT_W'(1),    32'hFFFF_FFFF);  // already free
        send_item(OP_NONE,    SLOT_W'(1023), 32'hFFFF_FFFF);
        send_item(OP_STORE,   SLOT_W'(1023), 32'h8000_0000);  // lowest free again

        write_slots(AVAIL_W'(2));
        send_item(OP_STORE,   '0,            32'h0000_1000);
        send_item(OP_STORE,   '0,            32'h0000_2000);  // full
        send_item(OP_LOAD,    SLOT_W'(2),    32'h0000_3000);  // index out of range
        send_item(OP_DISCARD, SLOT_W'(1023), 32'h0000_0000);
        send_item(OP_DISCARD, SLOT_W'(0),    32'h0000_0000);
        send_item(OP_LOAD,    SLOT_W'(1),    32'hAAAA_AAAA);

        write_slots(AVAIL_W'(0));
        send_item(OP_STORE,   '0,            32'h5555_5555);
        send_item(OP_LOAD,    SLOT_W'(0),    32'h5555_5555);
        send_item(OP_DISCARD, SLOT_W'(0),    32'h0000_0000);

        write_slots(AVAIL_W'(2047));
        send_item(OP_STORE,   '0,            32'h0001_0000);
        send_item(OP_LOAD,    SLOT_W'(1023), 32'h5555_5555);
        repeat (4) send_item(OP_STORE, '0, $urandom);

        // shrink below used slots: slot 4 stays used but out of reach
        write_slots(AVAIL_W'(3));
        send_item(OP_LOAD,    SLOT_W'(4),    32'h0002_0000);
        send_item(OP_STORE,   '0,            32'h0003_0000);
        write_slots(AVAIL_W'(1024));
        send_item(OP_DISCARD, SLOT_W'(4),    32'h0000_0000);

        phase_slots[0] = AVAIL_W'(1);
        phase_slots[1] = AVAIL_W'(40);
        phase_slots[2] = AVAIL_W'(1024);
        phase_slots[3] = AVAIL_W'(7);
        phase_slots[4] = AVAIL_W'(2047);
        phase_slots[5] = AVAIL_W'($urandom_range(1, 2047));
        phase_slots[6] = AVAIL_W'(33);
        phase_slots[7] = AVAIL_W'(1024);

        for (p = 0; p < PHASES; p++) begin
            write_slots(phase_slots[p]);
            calm  = (p == PHASES - 1);
            limit = (int'(slots_setting) > SLOTS) ? SLOTS : int'(slots_setting);
            n     = 0;
            while (n < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)       op = OP_NONE;
                else if (roll < 55) op = OP_STORE;
                else if (roll < 82) op = OP_LOAD;
                else                op = OP_DISCARD;
                // stores fill from the bottom, so low indexes mostly hit used slots
                roll = $urandom_range(0, 99);
                if (roll < 70)      idx = SLOT_W'($urandom_range(0, (limit < 48 ? limit : 48) - 1));
                else if (roll < 85) idx = SLOT_W'($urandom_range(0, limit - 1));
                else                idx = SLOT_W'($urandom);
                send_item(op, idx, $urandom);
                if (op != OP_NONE) n++;
                if (n == PHASE_ITEMS / 2 && op != OP_NONE) wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/ssa_pkg.sv
sv/ssa_ram.sv
sv/ssa_alloc.sv
sv/ssa_emit.sv
sv/swap_slot_allocator_unit.sv
test/slot_beat_checker.sv
test/swap_slot_allocator_unit_tb.sv
